[sv/gbd_pkg.sv]
// Shared types and constants for the grid shortest-path block.
package gbd_pkg;

	localparam int IDX_W   = 10;
	localparam int STEPS_W = 10;
	localparam int DIM_W   = 6;
	localparam logic [STEPS_W-1:0] STEPS_MAX = 10'd1023;

	// Item function codes
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Configuration register indexes
	localparam logic REG_NUM_ROWS = 1'b0;
	localparam logic REG_NUM_COLS = 1'b1;

	typedef struct packed {
		logic             func;
		logic [IDX_W-1:0] cell_index;
		logic             cell_open;
		logic [IDX_W-1:0] start_cell;
		logic [IDX_W-1:0] goal_cell;
	} in_item_t;

	typedef struct packed {
		logic [STEPS_W-1:0] path_steps;
		logic               unreachable;
	} out_item_t;

endpackage

[sv/gbd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module gbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[sv/grid_bfs_distance.sv]
// Breadth-first shortest-path distance on a 4-neighbor grid held in on-chip memories.
// A load item (func 0) writes one open/blocked cell. A query item (func 1) first
// sweeps the visit memory, one entry a cycle, then does the range checks, then finds
// the start row by repeated subtraction, then walks the frontier queue: it reads each
// dequeued cell's entry and open bit, and for an open one tries each of the four
// neighbor directions, reading the open and visit memories for each in-grid neighbor.
// The result sits in an output register; the next item is taken once the search has
// handed its result there.
module grid_bfs_distance
	import gbd_pkg::*;
#(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic             cfg_index,
	input  logic [DIM_W-1:0] cfg_data
);

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RDW   = $clog2(MAX_ROWS + 1);
	localparam int CDW   = $clog2(MAX_COLS + 1);
	localparam int TW    = $clog2(CELLS + 1);
	localparam int QW    = AW + RW + CW + STEPS_W;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_CLEAR = 11'b00000000010,
		ST_CHECK = 11'b00000000100,
		ST_DIV   = 11'b00000001000,
		ST_SEED  = 11'b00000010000,
		ST_POP   = 11'b00000100000,
		ST_QWAIT = 11'b00001000000,
		ST_OWAIT = 11'b00010000000,
		ST_NSEL  = 11'b00100000000,
		ST_NWAIT = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t state_q;

	logic [DIM_W-1:0]   rows_q, cols_q;
	logic [RDW-1:0]     rows_c_q;
	logic [CDW-1:0]     cols_c_q;
	logic [TW-1:0]      total_q;
	logic [IDX_W-1:0]   start_q, goal_q, rem_q;
	logic [RW-1:0]      srow_q;
	logic [AW:0]        clr_q;
	logic [AW:0]        head_q, tail_q;
	logic [AW-1:0]      v_q, n_q;
	logic [RW-1:0]      vr_q, nr_q;
	logic [CW-1:0]      vc_q, nc_q;
	logic [STEPS_W-1:0] vd_q;
	logic [1:0]         k_q;
	out_item_t          res_q, out_q;
	logic               out_valid_q;

	// Memory ports
	logic          open_we, open_rd;
	logic [AW-1:0] open_waddr, open_raddr;
	logic          visit_we, visit_wdata, visit_rd;
	logic [AW-1:0] visit_waddr, visit_raddr;
	logic          q_we;
	logic [AW-1:0] q_waddr, q_raddr;
	logic [QW-1:0] q_wdata, q_rdata;

	logic               in_fire, out_free;
	logic [RDW-1:0]     rows_c;
	logic [CDW-1:0]     cols_c;
	logic               nb_ok;
	logic [AW-1:0]      nb_idx;
	logic [RW-1:0]      nb_row;
	logic [CW-1:0]      nb_col;
	logic [STEPS_W-1:0] next_d;
	logic [AW-1:0]      qv;

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Clamp the register values to the grid that the memories hold
	always_comb begin
		if (rows_q == '0) begin
			rows_c = RDW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			rows_c = RDW'(MAX_ROWS);
		end else begin
			rows_c = RDW'(rows_q);
		end
		if (cols_q == '0) begin
			cols_c = CDW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			cols_c = CDW'(MAX_COLS);
		end else begin
			cols_c = CDW'(cols_q);
		end
	end

	// Pick the neighbor that k_q names and whether it lies inside the grid
	always_comb begin
		nb_ok  = 1'b0;
		nb_idx = v_q;
		nb_row = vr_q;
		nb_col = vc_q;
		case (k_q)
			2'd0: begin
				nb_ok  = (vc_q != '0);
				nb_idx = v_q - AW'(1);
				nb_col = vc_q - CW'(1);
			end
			2'd1: begin
				nb_ok  = ((CW+1)'(vc_q) + (CW+1)'(1)) < cols_c_q;
				nb_idx = v_q + AW'(1);
				nb_col = vc_q + CW'(1);
			end
			2'd2: begin
				nb_ok  = (vr_q != '0);
				nb_idx = v_q - AW'(cols_c_q);
				nb_row = vr_q - RW'(1);
			end
			2'd3: begin
				nb_ok  = ((RW+1)'(vr_q) + (RW+1)'(1)) < rows_c_q;
				nb_idx = v_q + AW'(cols_c_q);
				nb_row = vr_q + RW'(1);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
	end

	assign next_d = (vd_q == STEPS_MAX) ? STEPS_MAX : vd_q + STEPS_W'(1);
	assign qv     = q_rdata[QW-1 -: AW];

	// Memory address and write control
	always_comb begin
		open_we     = in_fire && (in_item.func == FUNC_LOAD) && (int'(in_item.cell_index) < CELLS);
		open_waddr  = AW'(in_item.cell_index);
		open_raddr  = (state_q == ST_QWAIT) ? qv : nb_idx;
		visit_raddr = nb_idx;
		visit_we    = 1'b0;
		visit_waddr = n_q;
		visit_wdata = 1'b1;
		q_we        = 1'b0;
		q_waddr     = tail_q[AW-1:0];
		q_wdata     = {n_q, nr_q, nc_q, next_d};
		q_raddr     = head_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				visit_we    = 1'b1;
				visit_waddr = clr_q[AW-1:0];
				visit_wdata = 1'b0;
			end
			ST_SEED: begin
				visit_we    = 1'b1;
				visit_waddr = AW'(start_q);
				q_we        = 1'b1;
				q_waddr     = '0;
				q_wdata     = {AW'(start_q), srow_q, CW'(rem_q), STEPS_W'(0)};
			end
			ST_NWAIT: begin
				visit_we = open_rd && !visit_rd && (AW'(goal_q) != n_q);
				q_we     = visit_we;
			end
			default: begin
				visit_we = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(32);
			cols_q <= DIM_W'(32);
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_NUM_ROWS) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == REG_NUM_COLS) begin
				cols_q <= cfg_data;
			end
		end
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			clr_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire && in_item.func == FUNC_QUERY) begin
						clr_q   <= '0;
						state_q <= ST_CLEAR;
					end
				end
				ST_CLEAR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (int'(clr_q) == CELLS - 1) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					head_q <= '0;
					tail_q <= (AW+1)'(1);
					if (start_q >= total_q || goal_q >= total_q || start_q == goal_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rem_q < cols_c_q) begin
						state_q <= ST_SEED;
					end
				end
				ST_SEED: begin
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						state_q <= ST_DONE;
					end else begin
						head_q  <= head_q + (AW+1)'(1);
						state_q <= ST_QWAIT;
					end
				end
				ST_QWAIT: begin
					k_q     <= '0;
					state_q <= ST_OWAIT;
				end
				ST_OWAIT: begin
					state_q <= open_rd ? ST_NSEL : ST_POP;
				end
				ST_NSEL: begin
					if (nb_ok) begin
						state_q <= ST_NWAIT;
					end else begin
						k_q     <= k_q + 2'd1;
						state_q <= (k_q == 2'd3) ? ST_POP : ST_NSEL;
					end
				end
				ST_NWAIT: begin
					k_q <= k_q + 2'd1;
					if (open_rd && !visit_rd && AW'(goal_q) == n_q) begin
						state_q <= ST_DONE;
					end else begin
						if (q_we) begin
							tail_q <= tail_q + (AW+1)'(1);
						end
						state_q <= (k_q == 2'd3) ? ST_POP : ST_NSEL;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query datapath: grid size, start row and column, current and neighbor cell, result
	always_ff @(posedge clk) begin
		if (in_fire && in_item.func == FUNC_QUERY) begin
			start_q  <= in_item.start_cell;
			goal_q   <= in_item.goal_cell;
			rem_q    <= in_item.start_cell;
			srow_q   <= '0;
			rows_c_q <= rows_c;
			cols_c_q <= cols_c;
		end
		if (state_q == ST_CLEAR) begin
			total_q <= TW'(rows_c_q) * TW'(cols_c_q);
		end
		if (state_q == ST_CHECK) begin
			res_q.path_steps  <= '0;
			res_q.unreachable <= (start_q != goal_q) || start_q >= total_q || goal_q >= total_q;
		end
		if (state_q == ST_DIV && rem_q >= cols_c_q) begin
			rem_q  <= rem_q - IDX_W'(cols_c_q);
			srow_q <= srow_q + RW'(1);
		end
		if (state_q == ST_POP && head_q == tail_q) begin
			res_q.path_steps  <= '0;
			res_q.unreachable <= 1'b1;
		end
		if (state_q == ST_QWAIT) begin
			{v_q, vr_q, vc_q, vd_q} <= q_rdata;
		end
		if (state_q == ST_NSEL) begin
			n_q  <= nb_idx;
			nr_q <= nb_row;
			nc_q <= nb_col;
		end
		if (state_q == ST_NWAIT && open_rd && !visit_rd && AW'(goal_q) == n_q) begin
			res_q.path_steps  <= next_d;
			res_q.unreachable <= 1'b0;
		end
	end

	// Output register: hold the result item until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	gbd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_open_ram (
		.clk   (clk),
		.we    (open_we),
		.waddr (open_waddr),
		.wdata (in_item.cell_open),
		.raddr (open_raddr),
		.rdata (open_rd)
	);

	gbd_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visit_ram (
		.clk   (clk),
		.we    (visit_we),
		.waddr (visit_waddr),
		.wdata (visit_wdata),
		.raddr (visit_raddr),
		.rdata (visit_rd)
	);

	gbd_ram #(.WIDTH(QW), .DEPTH(CELLS)) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

`ifndef SYNTHESIS
	a_head_le_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tail_q) <= CELLS) else $error("queue tail beyond capacity");
	a_query_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_item.func == FUNC_QUERY) |=> state_q == ST_CLEAR)
		else $error("query did not start the visit sweep");
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.unreachable) |-> out_q.path_steps == '0)
		else $error("unreachable result carries a distance");
`endif

endmodule

[test/grid_bfs_distance_tb.sv]
// Testbench for the grid shortest-path block: directed and random loads and queries.
module grid_bfs_distance_tb;
	import gbd_pkg::*;

	localparam int CELLS = 1024;
	localparam int SNAKE_N = 6;
	localparam longint CYCLE_LIMIT = 64'd20000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_NUM_ROWS;
	logic [DIM_W-1:0] cfg_data = '0;

	grid_bfs_distance DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Predictor state
	logic [DIM_W-1:0] rows_reg = 6'd32;
	logic [DIM_W-1:0] cols_reg = 6'd32;
	logic grid_open [CELLS];
	out_item_t distance_fifo [$];

	int mismatches = 0;
	int queries_sent = 0;
	int loads_sent = 0;
	int results_seen = 0;
	int unreach_seen = 0;
	longint cycle_count = 0;
	bit hold_off = 1'b0;
	int hold_cycles = 0;

	function automatic int clamp_dim(logic [DIM_W-1:0] v);
		if (v == 0) return 1;
		if (v > 32) return 32;
		return int'(v);
	endfunction

	// Breadth-first search over the predictor's copy of the grid
	function automatic out_item_t predict_distance(int s, int g);
		int rows, cols, total, head, tail, v, r, c, n, k;
		int level [CELLS];
		int fifo [CELLS];
		int nb [4];
		int cnt;
		out_item_t res;
		rows = clamp_dim(rows_reg);
		cols = clamp_dim(cols_reg);
		total = rows * cols;
		res.path_steps = '0;
		res.unreachable = 1'b1;
		if (s >= total || g >= total) return res;
		if (s == g) begin
			res.unreachable = 1'b0;
			return res;
		end
		foreach (level[i]) level[i] = -1;
		level[s] = 0;
		head = 0;
		tail = 1;
		fifo[0] = s;
		while (head < tail) begin
			v = fifo[head];
			head++;
			if (!grid_open[v]) continue;
			r = v / cols;
			c = v % cols;
			cnt = 0;
			if (c > 0) begin nb[cnt] = v - 1; cnt++; end
			if (c + 1 < cols) begin nb[cnt] = v + 1; cnt++; end
			if (r > 0) begin nb[cnt] = v - cols; cnt++; end
			if (r + 1 < rows) begin nb[cnt] = v + cols; cnt++; end
			for (k = 0; k < cnt; k++) begin
				n = nb[k];
				if (!grid_open[n] || level[n] >= 0) continue;
				level[n] = level[v] + 1;
				if (n == g) begin
					res.unreachable = 1'b0;
					res.path_steps = (level[n] > 1023) ? STEPS_MAX : STEPS_W'(level[n]);
					return res;
				end
				fifo[tail] = n;
				tail++;
			end
		end
		return res;
	endfunction

	// Send one item, update the predictor when accepted
	task automatic send_item(in_item_t it);
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (it.func == FUNC_LOAD) begin
			loads_sent++;
			if (it.cell_index < CELLS) begin
				grid_open[it.cell_index] = it.cell_open;
			end
		end else begin
			queries_sent++;
			distance_fifo = {distance_fifo, predict_distance(it.start_cell, it.goal_cell)};
		end
		// random gap between bursts
		if ($urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic load_cell(int idx, bit op);
		in_item_t it;
		it = '0;
		it.func = FUNC_LOAD;
		it.cell_index = IDX_W'(idx);
		it.cell_open = op;
		it.start_cell = IDX_W'($urandom);
		it.goal_cell = IDX_W'($urandom);
		send_item(it);
	endtask

	task automatic query_pair(int s, int g);
		in_item_t it;
		it = '0;
		it.func = FUNC_QUERY;
		it.cell_index = IDX_W'($urandom);
		it.cell_open = 1'($urandom);
		it.start_cell = IDX_W'(s);
		it.goal_cell = IDX_W'(g);
		send_item(it);
	endtask

	// Wait until all results are in, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (distance_fifo.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [DIM_W-1:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_NUM_ROWS) rows_reg = val;
		else rows_reg = rows_reg;
		if (idx == REG_NUM_COLS) cols_reg = val;
		@(posedge clk);
	endtask

	// Query cells restricted to the written part of the grid, or out of it
	function automatic int pick_cell(int total);
		if ($urandom_range(0, 15) == 0) return $urandom_range(total, 1023);
		return $urandom_range(0, total - 1);
	endfunction

	task automatic fill_grid(int total, int open_pct);
		for (int i = 0; i < total; i++)
			load_cell(i, $urandom_range(0, 99) < open_pct);
	endtask

	// Extremes: a 1x1 grid, register zero and overflow, bit patterns of load indexes
	task automatic test_directed();
		write_reg(REG_NUM_ROWS, 6'd0);
		write_reg(REG_NUM_COLS, 6'd63);
		// one row of 32 open cells except one blocked
		for (int i = 0; i < 32; i++) load_cell(i, i != 20);
		query_pair(0, 0);
		query_pair(0, 19);
		query_pair(0, 31);
		query_pair(20, 20);
		query_pair(20, 21);
		query_pair(32, 32);
		query_pair(1023, 0);
		query_pair(0, 1023);
		load_cell(1023, 1'b1);
		load_cell(682, 1'b0);
		load_cell(341, 1'b1);
		drain();
		write_reg(REG_NUM_ROWS, 6'd1);
		write_reg(REG_NUM_COLS, 6'd1);
		load_cell(0, 1'b0);
		query_pair(0, 0);
		query_pair(1, 0);
		drain();
	endtask

	// Snake maze on a square grid gives a long winding path
	task automatic test_long_path();
		write_reg(REG_NUM_ROWS, DIM_W'(SNAKE_N));
		write_reg(REG_NUM_COLS, DIM_W'(SNAKE_N));
		for (int i = 0; i < SNAKE_N * SNAKE_N; i++) begin
			int r, c;
			r = i / SNAKE_N;
			c = i % SNAKE_N;
			grid_open[i] = (r % 2 == 0) || (r % 4 == 1 && c == SNAKE_N - 1) ||
				(r % 4 == 3 && c == 0);
		end
		for (int i = 0; i < SNAKE_N * SNAKE_N; i++) load_cell(i, grid_open[i]);
		query_pair(0, SNAKE_N * SNAKE_N - 1);
		query_pair(0, (SNAKE_N - 2) * SNAKE_N);
		query_pair(SNAKE_N - 1, SNAKE_N + 1);
		drain();
	endtask

	// Random small grids
	task automatic test_random();
		for (int phase = 0; phase < 4; phase++) begin
			int rows, cols, total, nq;
			rows = $urandom_range(1, 4);
			cols = $urandom_range(1, 4);
			write_reg(REG_NUM_ROWS, DIM_W'(rows));
			write_reg(REG_NUM_COLS, DIM_W'(cols));
			total = rows * cols;
			fill_grid(total, $urandom_range(55, 90));
			nq = 5;
			for (int k = 0; k < nq; k++) begin
				if ($urandom_range(0, 4) == 0)
					load_cell($urandom_range(0, total - 1), 1'($urandom));
				query_pair(pick_cell(total), pick_cell(total));
			end
			drain();
		end
	endtask

	// Receiver holds off long enough to stall input
	task automatic test_backpressure();
		write_reg(REG_NUM_ROWS, 6'd3);
		write_reg(REG_NUM_COLS, 6'd3);
		fill_grid(9, 80);
		hold_cycles = 3000;
		hold_off = 1'b1;
		for (int k = 0; k < 6; k++) query_pair($urandom_range(0, 8), $urandom_range(0, 8));
		drain();
	endtask

	// Receiver stall pattern and long hold-off
	always @(posedge clk) begin
		if (hold_off) begin
			out_ready <= 1'b0;
			if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
			else hold_off <= 1'b0;
		end else begin
			out_ready <= (cycle_count % 64 < 32) ? 1'b1 : ($urandom_range(0, 2) != 0);
		end
	end

	// Check each result against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			out_item_t exp_item;
			results_seen++;
			if (out_item.unreachable) unreach_seen++;
			if (distance_fifo.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result steps=%0d unr=%0b",
					out_item.path_steps, out_item.unreachable);
			end else begin
				exp_item = distance_fifo.pop_front();
				if (out_item.path_steps !== exp_item.path_steps ||
						out_item.unreachable !== exp_item.unreachable) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected steps=%0d unr=%0b, got steps=%0d unr=%0b",
							exp_item.path_steps, exp_item.unreachable,
							out_item.path_steps, out_item.unreachable);
				end
			end
		end
	end

	// Timeout
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		foreach (grid_open[i]) grid_open[i] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_long_path();
		test_random();
		test_backpressure();
		if (distance_fifo.size() != 0) mismatches++;
		$display("Covered %0d loads and %0d queries, %0d results (%0d unreachable).",
			loads_sent, queries_sent, results_seen, unreach_seen);
		if (mismatches == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule
